>>> src/cngram_pkg.sv
// ----------------------------------------------------------------------------
// cngram_pkg - shared types and constants
// Symbol coding, histogram geometry, opcodes and the cleaner-to-core bump
// record of the character n-gram histogram.
// ----------------------------------------------------------------------------
package cngram_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int OUT_W       = 32;
    localparam int SYM_W       = 6;
    localparam int SYMS        = 36;
    localparam int BI_DEPTH    = SYMS * SYMS;
    localparam int TRI_DEPTH   = SYMS * SYMS * SYMS;
    localparam int BI_AW       = $clog2(BI_DEPTH);
    localparam int TRI_AW      = $clog2(TRI_DEPTH);

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_LO    = 8'd32;
    localparam logic [7:0] CH_HI    = 8'd126;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_HYPH  = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        OP_FEED   = 2'd0,
        OP_RD_BI  = 2'd1,
        OP_RD_TRI = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        PH_DIG  = 3'b001,
        PH_WS   = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    typedef struct packed {
        logic              bi_en;
        logic              tr_en;
        logic [BI_AW-1:0]  bi_idx;
        logic [TRI_AW-1:0] tr_idx;
    } t_bump;

    // clamp a counter to the 32-bit result field
    function automatic logic [OUT_W-1:0] clamp_count(input logic [COUNT_WIDTH-1:0] c);
        logic [63:0] v;
        v = 64'(c);
        if (v > 64'(32'hFFFF_FFFF)) begin
            return '1;
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

>>> src/cngram_ram.sv
// ----------------------------------------------------------------------------
// cngram_ram - generic single-port synchronous RAM
// One access per cycle, write or read; read data registered and held.
// ----------------------------------------------------------------------------
module cngram_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/cngram_clean.sv
// ----------------------------------------------------------------------------
// cngram_clean - text cleaner and word tracker
// Strips line prefixes, handles apostrophes and hyphens, codes symbols and
// tells the core which bigram and trigram counters a byte bumps.
// ----------------------------------------------------------------------------
module cngram_clean (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic [7:0]           i_byte,
    output cngram_pkg::t_bump    o_bump
);
    import cngram_pkg::*;

    t_phase           r_phase, n_phase;
    logic             r_prev,  n_prev;
    logic             r_hp,    n_hp;
    logic             r_hla,   n_hla;
    logic [1:0]       r_wl,    n_wl;
    logic [11:0]      r_ls,    n_ls;

    logic             is_alpha, is_upper, is_digit, is_space, is_print;
    logic [SYM_W-1:0] sym;
    logic [1:0]       wl_w;
    logic [11:0]      ls_w;
    t_bump            bump;

    always_comb begin
        is_upper = (i_byte >= "A") && (i_byte <= "Z");
        is_alpha = is_upper || ((i_byte >= "a") && (i_byte <= "z"));
        is_digit = (i_byte >= "0") && (i_byte <= "9");
        is_space = (i_byte == CH_SPACE) || ((i_byte >= 8'd9) && (i_byte <= 8'd13));
        is_print = (i_byte >= CH_LO) && (i_byte <= CH_HI);
        priority if (is_digit) begin
            sym = SYM_W'(i_byte - "0");
        end else if (is_upper) begin
            sym = SYM_W'(i_byte - "A" + 8'd10);
        end else begin
            sym = SYM_W'(i_byte - "a" + 8'd10);
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_prev  = r_prev;
        n_hp    = r_hp;
        n_hla   = r_hla;
        n_wl    = r_wl;
        n_ls    = r_ls;
        wl_w    = r_wl;
        ls_w    = r_ls;
        bump    = '0;
        priority if (i_byte == CH_NL) begin
            n_phase = PH_DIG;
            n_prev  = 1'b0;
            n_hp    = 1'b0;
            n_hla   = 1'b0;
            n_wl    = '0;
            n_ls    = '0;
        end else if (r_phase == PH_DIG && is_digit) begin
            n_phase = PH_DIG;
        end else if (r_phase != PH_BODY && is_space) begin
            n_phase = PH_WS;
        end else begin
            n_phase = PH_BODY;
            // pending hyphen resolves on its right neighbour
            if (r_hp) begin
                if (!(r_hla && is_alpha)) begin
                    wl_w = '0;
                    ls_w = '0;
                end
                n_hp  = 1'b0;
                n_hla = 1'b0;
            end
            priority if (!is_print) begin
                wl_w = '0;
                ls_w = '0;
            end else if (i_byte == CH_APOS) begin
                wl_w = wl_w;
            end else if (i_byte == CH_HYPH) begin
                n_hp  = 1'b1;
                n_hla = r_prev;
            end else if (is_alpha || is_digit) begin
                bump.bi_en  = (wl_w != 2'd0);
                bump.tr_en  = (wl_w == 2'd2);
                bump.bi_idx = BI_AW'(ls_w[5:0]) * BI_AW'(SYMS) + BI_AW'(sym);
                bump.tr_idx = TRI_AW'(ls_w[11:6]) * TRI_AW'(SYMS * SYMS)
                            + TRI_AW'(ls_w[5:0]) * TRI_AW'(SYMS) + TRI_AW'(sym);
                ls_w = {ls_w[5:0], sym};
                if (wl_w != 2'd2) begin
                    wl_w = wl_w + 2'd1;
                end
            end else begin
                wl_w = '0;
                ls_w = '0;
            end
            n_wl   = wl_w;
            n_ls   = ls_w;
            n_prev = is_alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DIG;
            r_prev  <= 1'b0;
            r_hp    <= 1'b0;
            r_hla   <= 1'b0;
            r_wl    <= '0;
            r_ls    <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
            r_hp    <= n_hp;
            r_hla   <= n_hla;
            r_wl    <= n_wl;
            r_ls    <= n_ls;
        end
    end

    assign o_bump = bump;

endmodule

>>> src/char_ngram_histogram.sv
// ----------------------------------------------------------------------------
// char_ngram_histogram - character bigram and trigram histogram
// Cleans a byte stream into words and keeps saturating bigram and trigram
// counters in two RAMs, read back by index.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_opcode, i_text_byte, i_ngram_index
//  output    out        o_valid / i_stall    o_count_value
//
//  After reset a clearing pass zeroes both RAMs, with o_stall high.
//  A feed beat that bumps no counter leaves the core idle; one that bumps goes
//  through accept, RAM read, and increment and write back.
//  A read beat goes through accept, RAM read and the output register, and waits
//  while i_stall holds an earlier result there; the next beat is taken as soon as the core is idle.
// ----------------------------------------------------------------------------
module char_ngram_histogram (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [7:0]                    i_text_byte,
    input  logic [15:0]                   i_ngram_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cngram_pkg::OUT_W-1:0]  o_count_value
);
    import cngram_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR   = 6'b000001,
        S_IDLE    = 6'b000010,
        S_BUMP_RD = 6'b000100,
        S_BUMP_WR = 6'b001000,
        S_READ_RD = 6'b010000,
        S_READ_OUT= 6'b100000
    } t_state;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    t_state               r_state, n_state;
    logic [TRI_AW-1:0]    r_clr;
    t_bump                r_bump;
    logic                 r_rd_tri;
    logic                 r_in_range;
    logic [TRI_AW-1:0]    r_index;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_count;

    t_op                  op;
    logic                 accept;
    t_bump                bump;
    logic                 out_free;

    logic                 bi_en, bi_we, tr_en, tr_we;
    logic [BI_AW-1:0]     bi_addr;
    logic [TRI_AW-1:0]    tr_addr;
    logic [COUNT_WIDTH-1:0] bi_wdata, tr_wdata, bi_rdata, tr_rdata, rd_count;

    assign op       = t_op'(i_opcode);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    cngram_clean u_clean (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept && op == OP_FEED),
        .i_byte    (i_text_byte),
        .o_bump    (bump)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:    if (r_clr == TRI_AW'(TRI_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    unique case (op)
                        OP_FEED:   if (bump.bi_en) n_state = S_BUMP_RD;
                        OP_RD_BI,
                        OP_RD_TRI: n_state = S_READ_RD;
                        OP_NONE:   n_state = S_IDLE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_BUMP_RD:  n_state = S_BUMP_WR;
            S_BUMP_WR:  n_state = S_IDLE;
            S_READ_RD:  n_state = S_READ_OUT;
            S_READ_OUT: if (out_free) n_state = S_IDLE;
            default:    n_state = S_CLEAR;
        endcase
    end

    // RAM port control
    always_comb begin
        bi_en    = 1'b0;
        bi_we    = 1'b0;
        tr_en    = 1'b0;
        tr_we    = 1'b0;
        bi_addr  = r_bump.bi_idx;
        tr_addr  = r_bump.tr_idx;
        bi_wdata = (bi_rdata == COUNT_MAX) ? bi_rdata : bi_rdata + 1'b1;
        tr_wdata = (tr_rdata == COUNT_MAX) ? tr_rdata : tr_rdata + 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                bi_addr  = r_clr[BI_AW-1:0];
                tr_addr  = r_clr;
                bi_wdata = '0;
                tr_wdata = '0;
                bi_en    = (r_clr < TRI_AW'(BI_DEPTH));
                bi_we    = bi_en;
                tr_en    = 1'b1;
                tr_we    = 1'b1;
            end
            S_BUMP_RD: begin
                bi_en = r_bump.bi_en;
                tr_en = r_bump.tr_en;
            end
            S_BUMP_WR: begin
                bi_en = r_bump.bi_en && (bi_rdata != COUNT_MAX);
                bi_we = bi_en;
                tr_en = r_bump.tr_en && (tr_rdata != COUNT_MAX);
                tr_we = tr_en;
            end
            S_READ_RD: begin
                bi_addr = r_index[BI_AW-1:0];
                tr_addr = r_index;
                bi_en   = !r_rd_tri;
                tr_en   = r_rd_tri;
            end
            S_IDLE, S_READ_OUT: begin
                bi_en = 1'b0;
            end
            default: begin
                bi_en = 1'b0;
            end
        endcase
    end

    cngram_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BI_DEPTH)) u_bi_ram (
        .i_clk   (i_clk),
        .i_en    (bi_en),
        .i_we    (bi_we),
        .i_addr  (bi_addr),
        .i_wdata (bi_wdata),
        .o_rdata (bi_rdata)
    );

    cngram_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TRI_DEPTH)) u_tri_ram (
        .i_clk   (i_clk),
        .i_en    (tr_en),
        .i_we    (tr_we),
        .i_addr  (tr_addr),
        .i_wdata (tr_wdata),
        .o_rdata (tr_rdata)
    );

    assign rd_count = r_rd_tri ? tr_rdata : bi_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_READ_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bump     <= bump;
            r_rd_tri   <= (op == OP_RD_TRI);
            r_index    <= i_ngram_index;
            r_in_range <= (op == OP_RD_TRI) ? (i_ngram_index < 16'(TRI_DEPTH))
                                            : (i_ngram_index < 16'(BI_DEPTH));
        end
        if (r_state == S_READ_OUT && out_free) begin
            r_count <= r_in_range ? clamp_count(rd_count) : '0;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_count_value = r_count;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for char_ngram_histogram
// Feeds short text lines (digit prefixes, hyphens, apostrophes, odd bytes)
// and counter reads through the valid/stall input channel. A behavioural
// copy of the text cleaner and both histograms predicts every read, and the
// monitor checks each returned count in order. Sender gaps and receiver
// stalls are random.
// ----------------------------------------------------------------------------
module tb;

    import cngram_pkg::*;

    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam int         N_BEATS  = 574;

    typedef struct {
        t_op         op;
        logic [7:0]  text;
        logic [15:0] ix;
        logic        drain;   // hold this beat back until every read has returned
    } t_host_beat;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_stall;
    logic [1:0]         i_opcode      = 2'd0;
    logic [7:0]         i_text_byte   = 8'd0;
    logic [15:0]        i_ngram_index = 16'd0;
    logic               o_valid;
    logic               i_stall       = 1'b0;
    logic [OUT_W-1:0]   o_count_value;

    char_ngram_histogram DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_text_byte   (i_text_byte),
        .i_ngram_index (i_ngram_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_count_value (o_count_value)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predicted histogram state
    // ------------------------------------------------------------------
    logic [COUNT_WIDTH-1:0] bigram_tally  [BI_DEPTH];
    logic [COUNT_WIDTH-1:0] trigram_tally [TRI_DEPTH];
    t_phase                 line_ph    = PH_DIG;
    logic                   prev_alpha = 1'b0;
    logic                   hyph_pend  = 1'b0;
    logic                   hyph_left  = 1'b0;
    logic [1:0]             word_len   = 2'd0;
    logic [11:0]            sym_hist   = 12'd0;

    t_host_beat       host_beats[$];
    logic [OUT_W-1:0] pending_counts[$];

    int  fails     = 0;
    int  n_feed    = 0;
    int  n_read    = 0;
    int  n_ignored = 0;
    int  n_checked = 0;
    int  n_queued  = 0;
    logic drain_next = 1'b0;

    task automatic end_word();
        word_len = 2'd0;
        sym_hist = 12'd0;
    endtask

    task automatic tally_symbol(input logic [5:0] s);
        int bi_ix;
        int tr_ix;
        bi_ix = (int'(sym_hist[5:0]) * SYMS + int'(s)) % BI_DEPTH;
        tr_ix = (int'(sym_hist[11:6]) * SYMS * SYMS + int'(sym_hist[5:0]) * SYMS
                 + int'(s)) % TRI_DEPTH;
        if (word_len >= 2'd1 && bigram_tally[bi_ix] != '1) begin
            bigram_tally[bi_ix] = bigram_tally[bi_ix] + 1'b1;
        end
        if (word_len >= 2'd2 && trigram_tally[tr_ix] != '1) begin
            trigram_tally[tr_ix] = trigram_tally[tr_ix] + 1'b1;
        end
        sym_hist = {sym_hist[5:0], s};
        if (word_len < 2'd2) begin
            word_len = word_len + 2'd1;
        end
    endtask

    task automatic clean_byte(input logic [7:0] c);
        logic       alpha;
        logic       digit;
        logic [7:0] low;
        low   = c | 8'h20;
        alpha = (low >= CH_LOW_A) && (low <= CH_LOW_A + 8'd25);
        digit = (c >= CH_ZERO) && (c <= CH_ZERO + 8'd9);
        if (c == CH_NL) begin
            end_word();
            hyph_pend  = 1'b0;
            hyph_left  = 1'b0;
            prev_alpha = 1'b0;
            line_ph    = PH_DIG;
        end else begin
            // prefix strip: digits first, then whitespace
            if (line_ph == PH_DIG && !digit) begin
                line_ph = PH_WS;
            end
            if (line_ph == PH_WS && !(c == CH_SPACE || (c >= 8'd9 && c <= 8'd13))) begin
                line_ph = PH_BODY;
            end
            if (line_ph == PH_BODY) begin
                if (hyph_pend) begin
                    if (!(hyph_left && alpha)) begin
                        end_word();
                    end
                    hyph_pend = 1'b0;
                    hyph_left = 1'b0;
                end
                if (c < CH_LO || c > CH_HI) begin
                    end_word();
                end else if (c == CH_APOS) begin
                    // dropped, word carries on
                end else if (c == CH_HYPH) begin
                    hyph_pend = 1'b1;
                    hyph_left = prev_alpha;
                end else if (alpha) begin
                    tally_symbol(6'(low - CH_LOW_A + 8'd10));
                end else if (digit) begin
                    tally_symbol(6'(c - CH_ZERO));
                end else begin
                    end_word();
                end
                prev_alpha = alpha;
            end
        end
    endtask

    task automatic predict_beat(input logic [1:0] op, input logic [7:0] b,
                                input logic [15:0] ix);
        logic [COUNT_WIDTH-1:0] raw;
        logic [63:0]            wide;
        raw = '0;
        case (op)
            OP_FEED: begin
                clean_byte(b);
                n_feed++;
            end
            OP_RD_BI, OP_RD_TRI: begin
                if (op == OP_RD_BI && ix < BI_DEPTH) begin
                    raw = bigram_tally[ix];
                end
                if (op == OP_RD_TRI && ix < TRI_DEPTH) begin
                    raw = trigram_tally[ix];
                end
                wide = 64'(raw);
                pending_counts.insert(pending_counts.size(),
                    (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0]);
                n_read++;
            end
            default: begin
                n_ignored++;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_beat(input t_op op, input logic [7:0] b, input logic [15:0] ix);
        t_host_beat hb;
        hb.op    = op;
        hb.text  = b;
        hb.ix    = ix;
        hb.drain = drain_next;
        drain_next = 1'b0;
        host_beats.insert(host_beats.size(), hb);
        n_queued++;
    endtask

    task automatic add_feed(input logic [7:0] b);
        add_beat(OP_FEED, b, 16'($urandom));
    endtask

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return CH_LOW_A + 8'($urandom_range(0, 4));
            5, 6:          return CH_LOW_A + 8'($urandom_range(0, 25));
            7:             return CH_UP_A + 8'($urandom_range(0, 25));
            default:       return CH_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [7:0] odd_byte();
        logic [7:0] b;
        b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31))
                                        : 8'($urandom_range(127, 255));
        return (b == CH_NL) ? 8'd0 : b;
    endfunction

    function automatic logic [7:0] sep_char();
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4: return CH_SPACE;
            5:             return ",";
            6:             return ".";
            7:             return CH_APOS;
            8, 9:          return CH_HYPH;
            10:            return 8'd9;
            default:       return odd_byte();
        endcase
    endfunction

    function automatic logic [15:0] pick_sym();
        return ($urandom_range(0, 4) != 0) ? 16'($urandom_range(10, 14))
                                           : 16'($urandom_range(0, 35));
    endfunction

    function automatic logic [15:0] read_index(input t_op op);
        logic [15:0] s1;
        logic [15:0] s2;
        logic [15:0] s3;
        s1 = pick_sym();
        s2 = pick_sym();
        s3 = pick_sym();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: begin
                case ($urandom_range(0, 5))
                    0:       return 16'd0;
                    1:       return 16'(BI_DEPTH - 1);
                    2:       return 16'(BI_DEPTH);
                    3:       return 16'(TRI_DEPTH - 1);
                    4:       return 16'(TRI_DEPTH);
                    default: return 16'hFFFF;
                endcase
            end
            default: begin
                if (op == OP_RD_BI) begin
                    return s1 * 16'(SYMS) + s2;
                end
                return s1 * 16'(SYMS * SYMS) + s2 * 16'(SYMS) + s3;
            end
        endcase
    endfunction

    task automatic add_read();
        t_op op;
        if ($urandom_range(0, 19) == 0) begin
            add_beat(OP_NONE, 8'($urandom), 16'($urandom));
        end else begin
            op = ($urandom_range(0, 1) == 0) ? OP_RD_BI : OP_RD_TRI;
            add_beat(op, 8'($urandom), read_index(op));
        end
    endtask

    task automatic add_line();
        int n_words;
        repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0) begin
            add_feed(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0:       add_feed(8'd9);
                1:       add_feed(8'd13);
                2:       add_feed(8'($urandom_range(11, 12)));
                default: add_feed(CH_SPACE);
            endcase
        end
        n_words = $urandom_range(1, 4);
        for (int w = 0; w < n_words; w++) begin
            repeat ($urandom_range(1, 7)) begin
                add_feed(word_char());
            end
            if (w != n_words - 1) begin
                add_feed(sep_char());
            end
        end
        if ($urandom_range(0, 4) == 0) begin
            add_feed(CH_HYPH);
        end
        add_feed(CH_NL);
    endtask

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    int gap_left   = 0;
    int burst_left = 1;

    always @(posedge i_clk) begin : drive
        t_host_beat nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_beat(i_opcode, i_text_byte, i_ngram_index);
            end
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (host_beats.size() != 0 &&
                             !(host_beats[0].drain && pending_counts.size() != 0)) begin
                    nxt = host_beats.pop_front();
                    i_valid       <= 1'b1;
                    i_opcode      <= nxt.op;
                    i_text_byte   <= nxt.text;
                    i_ngram_index <= nxt.ix;
                    if (burst_left <= 1) begin
                        burst_left <= ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor and receiver stall pattern
    // ------------------------------------------------------------------
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int rx_hold      = 0;

    always @(posedge i_clk) begin : watch
        logic [OUT_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_counts.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, o_count_value);
                fails++;
            end else begin
                want = pending_counts.pop_front();
                n_checked++;
                if (want !== o_count_value) begin
                    $display("%0t: count mismatch, expected %0d, actual %0d",
                             $time, want, o_count_value);
                    fails++;
                end
            end
        end

        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 2);
            rx_mode_left <= $urandom_range(100, 300);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end

        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            i_stall <= 1'b1;
        end else begin
            case (rx_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: begin
                    if ($urandom_range(0, 5) == 0) begin
                        rx_hold <= $urandom_range(1, 8);
                        i_stall <= 1'b1;
                    end else begin
                        i_stall <= 1'b0;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // run control
    // ------------------------------------------------------------------
    initial begin
        logic drained;
        drained = 1'b0;
        for (int k = 0; k < BI_DEPTH; k++) begin
            bigram_tally[k] = '0;
        end
        for (int k = 0; k < TRI_DEPTH; k++) begin
            trigram_tally[k] = '0;
        end

        // digit prefix, leading hyphen, apostrophe, joining hyphen, odd bytes,
        // trailing hyphen
        add_feed("7");
        add_feed(CH_SPACE);
        add_feed(CH_HYPH);
        add_feed("A");
        add_feed("b");
        add_feed(CH_APOS);
        add_feed("c");
        add_feed(CH_HYPH);
        add_feed("d");
        add_feed("9");
        add_feed(8'h01);
        add_feed("z");
        add_feed(8'hFF);
        add_feed("q");
        add_feed(CH_HYPH);
        add_feed(CH_NL);
        add_beat(OP_RD_BI,  8'hFF, 16'd371);      // ab
        add_beat(OP_RD_TRI, 8'h00, 16'd13368);    // abc
        add_beat(OP_RD_TRI, 8'hFF, 16'd14701);    // bcd, across the hyphen
        add_beat(OP_RD_BI,  8'h00, 16'hFFFF);
        add_beat(OP_RD_TRI, 8'hFF, 16'hFFFF);
        add_beat(OP_RD_BI,  8'h00, 16'(BI_DEPTH));
        add_beat(OP_RD_TRI, 8'hFF, 16'(TRI_DEPTH));
        add_beat(OP_NONE,   8'hFF, 16'hFFFF);

        drain_next = 1'b1;
        while (n_queued < N_BEATS) begin
            if (!drained && n_queued >= N_BEATS / 2) begin
                drain_next = 1'b1;
                drained    = 1'b1;
            end
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 10)) begin
                    add_feed(($urandom_range(0, 3) == 0) ? odd_byte() : 8'($urandom));
                end
                add_feed(CH_NL);
            end else begin
                add_line();
            end
            repeat ($urandom_range(1, 3)) begin
                add_read();
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (host_beats.size() != 0 || i_valid || pending_counts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        $display("Fed %0d text bytes, checked %0d of %0d counter reads,",
                 n_feed, n_checked, n_read);
        $display("and sent %0d unused-opcode beats.", n_ignored);
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout, %0d reads outstanding", $time, pending_counts.size());
        $display("Verification failed");
        $finish;
    end

endmodule

>>> char_ngram_histogram.f
src/cngram_pkg.sv
src/cngram_ram.sv
src/cngram_clean.sv
src/char_ngram_histogram.sv
tb/tb.sv
